// ===== hdl/ecpi_pkg.sv =====
// Shared types and constants of the encoder PI speed controller.
// No dependencies; every other file of the block imports this package.
package ecpi_pkg;

    // field widths
    localparam int KP_W       = 28;
    localparam int KSUM_W     = KP_W + 1;
    localparam int WORD16_W   = 16;
    localparam int POS_W      = 12;
    localparam int E_W        = 17;
    localparam int U_W        = 40;
    localparam int ACC_W      = 49;
    localparam int MB_W       = 18;
    localparam int PROD_W     = KSUM_W + 1 + MB_W;
    localparam int HALF_W     = 20;
    localparam int PART_W     = HALF_W + WORD16_W;
    localparam int DSUM_W     = 57;
    localparam int DIV_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 28;
    localparam int IN_TDATA_W = 8;
    localparam int IN_TUSER_W = 2;

    // result word layout, lowest bit first
    localparam int OUT_DIR_BIT  = 0;
    localparam int OUT_DUTY_LSB = 1;
    localparam int OUT_RPM_LSB  = 17;
    localparam int OUT_POS_LSB  = 33;
    localparam int OUT_ROT_BIT  = 45;
    localparam int OUT_RUN_BIT  = 46;
    localparam int OUT_TDATA_W  = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_TS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_POINT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_PV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PER   = 3'd4;

    // register reset values
    localparam logic [KP_W-1:0]     KP_RST        = 28'd335544;
    localparam logic [KP_W-1:0]     KI_TS_RST     = 28'd3355;
    localparam logic [WORD16_W-1:0] SET_POINT_RST = 16'd1000;
    localparam logic [WORD16_W-1:0] DUTY_PV_RST   = 16'd21333;
    localparam logic [WORD16_W-1:0] PWM_PER_RST   = 16'd1000;

    typedef enum logic [IN_TUSER_W-1:0] {
        REQ_EDGE    = 2'd0,
        REQ_MEASURE = 2'd1,
        REQ_CONTROL = 2'd2,
        REQ_KEY     = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        MUL_RPM  = 3'd0,
        MUL_KSUM = 3'd1,
        MUL_KP   = 3'd2,
        MUL_LO   = 3'd3,
        MUL_HI   = 3'd4
    } t_mul_op;

    typedef struct packed {
        t_mul_op mul_op;
        logic    mul_en;
        logic    edge_upd;
        logic    key_upd;
        logic    pulse_clr;
        logic    div_start;
        logic    div_sel;
        logic    rpm_en;
        logic    pos_en;
        logic    prep_en;
        logic    acc_en;
        logic    sat_en;
        logic    abs_en;
        logic    dlo_en;
        logic    fin_en;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic loop_on;
    } t_stat;

endpackage

// ===== hdl/encoder_pi_speed_controller.sv =====
// Top level of the encoder PI speed controller: stream ports, settings port,
// sequencer and datapath. Depends on ecpi_pkg, ecpi_ctrl and ecpi_dp.
//
// One input word carries one event (tuser: encoder A edge, measure tick,
// control tick, start/stop key) and produces exactly one result word with
// the state after that event. Events are handled one at a time; the input
// takes a new word as soon as the previous event has finished, even while
// its result still waits in the output register. Encoder edges, keys and
// control ticks while stopped are accepted, then the result is loaded. A
// control tick while running steps through the PI update and the duty
// scaling, which share one 29x18 multiplier over four products. A measure
// tick first forms the pulses times RPM_SCALE product, then rpm and the
// shaft position each go through a reciprocal divider by COUNTS_PER_REV
// (launch, three steps, take the result). While the previous result has not
// been taken, hold the last cycle of an event until it is. Settings may be
// written at any cycle while no event is in flight; a write to an index
// beyond the list is dropped. No start-up pass is needed after reset.
module encoder_pi_speed_controller #(
    parameter int COUNTS_PER_REV = 1024,
    parameter int RPM_SCALE      = 6000
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // settings write port
    input  logic                                i_cfg_wr_en,
    input  logic [ecpi_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ecpi_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // event stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [ecpi_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // [0] b_level, [7:1] zero
    input  logic [ecpi_pkg::IN_TUSER_W-1:0]     i_s_tuser,  // [1:0] req_type
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [0] drive_dir, [16:1] duty, [32:17] speed_rpm, [44:33] shaft_position,
    // [45] rotation_dir, [46] running, [47] zero
    output logic [ecpi_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import ecpi_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    t_req  req;

    // event kind straight from the sideband
    assign req = t_req'(i_s_tuser);

    ecpi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .i_in_req    (req),
        .o_in_ready  (o_s_tready),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // the b level is used only in the accept cycle of an encoder edge
    ecpi_dp #(
        .COUNTS_PER_REV (COUNTS_PER_REV),
        .RPM_SCALE      (RPM_SCALE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_b_level   (i_s_tdata[0]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_m_tdata)
    );

endmodule

// ===== hdl/ecpi_div.sv =====
// Division by a constant through reciprocal multiplication.
// Depends on ecpi_pkg for the dividend and remainder widths.
module ecpi_div #(
    parameter int DIVISOR = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ecpi_pkg::DIV_W-1:0]  i_dividend,
    output logic                        o_busy,
    output logic [ecpi_pkg::DIV_W-1:0]  o_quotient,
    output logic [ecpi_pkg::POS_W-1:0]  o_remainder
);
    import ecpi_pkg::*;

    // a dividend at or above SAT_LIM gives a quotient beyond 16 bits, so only
    // 28 dividend bits ever reach the reciprocal product
    localparam int XW    = 28;
    localparam int RCP_W = XW + 1;
    localparam int PRD_W = XW + RCP_W;
    localparam int SH    = XW + $clog2(DIVISOR);
    localparam logic [63:0] RCP_FULL =
        ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RCP_W-1:0] RCP     = RCP_FULL[RCP_W-1:0];
    localparam logic [DIV_W-1:0] SAT_LIM = DIV_W'(64'(DIVISOR) << WORD16_W);
    localparam logic [DIV_W-1:0] DVS     = DIV_W'(DIVISOR);

    logic [2:0]       r_stage;    // one bit per step
    logic [DIV_W-1:0] r_x;
    logic             r_over;
    logic [PRD_W-1:0] r_prd;
    logic [XW-1:0]    r_q;
    logic [DIV_W-1:0] r_quo;
    logic [POS_W-1:0] r_rem;

    logic [DIV_W-1:0] qd;

    assign qd = {{(DIV_W-XW){1'b0}}, r_q} * DVS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
        end else begin
            r_stage <= {r_stage[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
        end
        if (r_stage[0]) begin
            r_prd  <= r_x[XW-1:0] * RCP;
            r_over <= (r_x >= SAT_LIM);
        end
        if (r_stage[1]) begin
            r_q <= XW'(r_prd >> SH);
        end
        // an oversized dividend returns all ones, enough to saturate
        if (r_stage[2]) begin
            r_quo <= r_over ? '1 : DIV_W'(r_q);
            r_rem <= POS_W'(r_x - qd);
        end
    end

    assign o_busy      = |r_stage;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== hdl/ecpi_ctrl.sv =====
// Sequencer of the speed controller: steps one event through the datapath.
// Depends on ecpi_pkg for the command and status structs.
module ecpi_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ecpi_pkg::t_req  i_in_req,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ecpi_pkg::t_stat i_stat,
    output ecpi_pkg::t_cmd  o_cmd
);
    import ecpi_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_OUT   = 15'h0002,
        S_MMUL  = 15'h0004,
        S_DIV1L = 15'h0008,
        S_DIV1W = 15'h0010,
        S_DIV2L = 15'h0020,
        S_DIV2W = 15'h0040,
        S_CPREP = 15'h0080,
        S_CMUL1 = 15'h0100,
        S_CMUL2 = 15'h0200,
        S_CSAT  = 15'h0400,
        S_CABS  = 15'h0800,
        S_DMUL1 = 15'h1000,
        S_DMUL2 = 15'h2000,
        S_CFIN  = 15'h4000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_req)
                        REQ_EDGE: begin
                            cmd.edge_upd = 1'b1;
                            n_state      = S_OUT;
                        end
                        REQ_MEASURE: n_state = S_MMUL;
                        REQ_CONTROL: n_state = i_stat.loop_on ? S_CPREP : S_OUT;
                        REQ_KEY: begin
                            cmd.key_upd = 1'b1;
                            n_state     = S_OUT;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_MMUL: begin
                cmd.mul_op    = MUL_RPM;
                cmd.mul_en    = 1'b1;
                cmd.pulse_clr = 1'b1;
                n_state       = S_DIV1L;
            end
            S_DIV1L: begin
                cmd.div_start = 1'b1;
                n_state       = S_DIV1W;
            end
            S_DIV1W: begin
                if (!i_stat.div_busy) begin
                    cmd.rpm_en = 1'b1;
                    n_state    = S_DIV2L;
                end
            end
            S_DIV2L: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                n_state       = S_DIV2W;
            end
            S_DIV2W: begin
                if (!i_stat.div_busy) begin
                    cmd.pos_en = 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_CPREP: begin
                cmd.prep_en = 1'b1;
                n_state     = S_CMUL1;
            end
            S_CMUL1: begin
                cmd.mul_op = MUL_KSUM;
                cmd.mul_en = 1'b1;
                n_state    = S_CMUL2;
            end
            S_CMUL2: begin
                cmd.acc_en = 1'b1;
                cmd.mul_op = MUL_KP;
                cmd.mul_en = 1'b1;
                n_state    = S_CSAT;
            end
            S_CSAT: begin
                cmd.sat_en = 1'b1;
                n_state    = S_CABS;
            end
            S_CABS: begin
                cmd.abs_en = 1'b1;
                n_state    = S_DMUL1;
            end
            S_DMUL1: begin
                cmd.mul_op = MUL_LO;
                cmd.mul_en = 1'b1;
                n_state    = S_DMUL2;
            end
            S_DMUL2: begin
                cmd.dlo_en = 1'b1;
                cmd.mul_op = MUL_HI;
                cmd.mul_en = 1'b1;
                n_state    = S_CFIN;
            end
            S_CFIN: begin
                cmd.fin_en = 1'b1;
                n_state    = S_OUT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== hdl/ecpi_dp.sv =====
// Datapath of the speed controller: settings, loop state, shared multiplier,
// divider and result word. Depends on ecpi_pkg and ecpi_div.
module ecpi_dp #(
    parameter int COUNTS_PER_REV = 1024,
    parameter int RPM_SCALE      = 6000
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [ecpi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ecpi_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_b_level,
    input  ecpi_pkg::t_cmd                    i_cmd,
    output ecpi_pkg::t_stat                   o_stat,
    output logic [ecpi_pkg::OUT_TDATA_W-1:0]  o_out_data
);
    import ecpi_pkg::*;

    // settings
    logic [KP_W-1:0]     r_kp, r_ki_ts;
    logic [WORD16_W-1:0] r_set_point, r_duty_pv, r_pwm_per;

    // loop state
    logic [WORD16_W-1:0] r_pulse, r_pos_cnt, r_rpm, r_target, r_duty;
    logic [POS_W-1:0]    r_pos;
    logic                r_spin, r_loop_on, r_drive_sign;
    logic [E_W-1:0]      r_prev_e;
    logic [U_W-1:0]      r_prev_u;

    // scratch
    logic [E_W-1:0]      r_e;
    logic [KSUM_W-1:0]   r_ksum;
    logic [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic [U_W-1:0]      r_u;
    logic [U_W-1:0]      r_mag;
    logic [PART_W-1:0]   r_dlo;
    logic [OUT_TDATA_W-1:0] r_out;

    // multiplier operands
    logic [KSUM_W-1:0]        mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_res;

    logic [DIV_W-1:0]    div_in, div_quo;
    logic [POS_W-1:0]    div_rem;
    logic                div_busy;

    logic [ACC_W-1:0]    u_full;
    logic [U_W-1:0]      u_sat;
    logic [DSUM_W-1:0]   d_sum;
    logic [24:0]         d_raw;
    logic [WORD16_W-1:0] d_clamp;
    logic [WORD16_W-1:0] rpm_sat;

    always_comb begin
        case (i_cmd.mul_op)
            MUL_KSUM: begin
                mul_a = r_ksum;
                mul_b = {r_e[E_W-1], r_e};
            end
            MUL_KP: begin
                mul_a = KSUM_W'(r_kp);
                mul_b = {r_prev_e[E_W-1], r_prev_e};
            end
            MUL_LO: begin
                mul_a = KSUM_W'(r_mag[HALF_W-1:0]);
                mul_b = {2'b00, r_duty_pv};
            end
            MUL_HI: begin
                mul_a = KSUM_W'(r_mag[U_W-1:HALF_W]);
                mul_b = {2'b00, r_duty_pv};
            end
            default: begin
                mul_a = KSUM_W'(r_pulse);
                mul_b = MB_W'(RPM_SCALE);
            end
        endcase
        mul_res = $signed({1'b0, mul_a}) * mul_b;
    end

    assign div_in = i_cmd.div_sel ? DIV_W'(r_pos_cnt) : r_prod[DIV_W-1:0];

    ecpi_div #(
        .DIVISOR (COUNTS_PER_REV)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (div_in),
        .o_busy      (div_busy),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        rpm_sat = (|div_quo[DIV_W-1:WORD16_W]) ? '1 : div_quo[WORD16_W-1:0];

        // saturate the exact sum to signed Q16.24
        u_full = r_acc - {r_prod[PROD_W-1], r_prod};
        if (u_full[ACC_W-1] && !(&u_full[ACC_W-1:U_W-1])) begin
            u_sat = {1'b1, {(U_W-1){1'b0}}};
        end else if (!u_full[ACC_W-1] && (|u_full[ACC_W-1:U_W-1])) begin
            u_sat = {1'b0, {(U_W-1){1'b1}}};
        end else begin
            u_sat = u_full[U_W-1:0];
        end

        // recombine the two partial products and drop the 32 fraction bits
        d_sum   = {1'b0, r_prod[PART_W-1:0], {HALF_W{1'b0}}}
                + {{(DSUM_W-PART_W){1'b0}}, r_dlo};
        d_raw   = d_sum[DSUM_W-1:32];
        d_clamp = (d_raw > {9'b0, r_pwm_per}) ? r_pwm_per : d_raw[WORD16_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp         <= KP_RST;
            r_ki_ts      <= KI_TS_RST;
            r_set_point  <= SET_POINT_RST;
            r_duty_pv    <= DUTY_PV_RST;
            r_pwm_per    <= PWM_PER_RST;
            r_pulse      <= '0;
            r_pos_cnt    <= '0;
            r_rpm        <= '0;
            r_pos        <= '0;
            r_spin       <= 1'b0;
            r_target     <= '0;
            r_prev_e     <= '0;
            r_prev_u     <= '0;
            r_loop_on    <= 1'b0;
            r_duty       <= '0;
            r_drive_sign <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_KP:        r_kp        <= i_cfg_data;
                    CFG_KI_TS:     r_ki_ts     <= i_cfg_data;
                    CFG_SET_POINT: r_set_point <= i_cfg_data[WORD16_W-1:0];
                    CFG_DUTY_PV:   r_duty_pv   <= i_cfg_data[WORD16_W-1:0];
                    CFG_PWM_PER:   r_pwm_per   <= i_cfg_data[WORD16_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.edge_upd) begin
                r_pulse   <= r_pulse + 1'b1;
                r_spin    <= i_b_level;
                r_pos_cnt <= i_b_level ? r_pos_cnt - 1'b1 : r_pos_cnt + 1'b1;
            end
            if (i_cmd.key_upd) begin
                r_loop_on <= !r_loop_on;
                if (!r_loop_on) begin
                    r_target <= r_set_point;
                end else begin
                    r_duty <= '0;
                end
            end
            if (i_cmd.pulse_clr) begin
                r_pulse <= '0;
            end
            if (i_cmd.rpm_en) begin
                r_rpm <= rpm_sat;
            end
            if (i_cmd.pos_en) begin
                r_pos <= div_rem;
            end
            if (i_cmd.fin_en) begin
                r_duty       <= d_clamp;
                r_drive_sign <= r_u[U_W-1];
                r_prev_e     <= r_e;
                r_prev_u     <= r_u;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_res;
        end
        if (i_cmd.prep_en) begin
            r_e    <= {1'b0, r_target} - {1'b0, r_rpm};
            r_ksum <= {1'b0, r_kp} + {1'b0, r_ki_ts};
        end
        if (i_cmd.acc_en) begin
            r_acc <= {{(ACC_W-U_W){r_prev_u[U_W-1]}}, r_prev_u}
                   + {r_prod[PROD_W-1], r_prod};
        end
        if (i_cmd.sat_en) begin
            r_u <= u_sat;
        end
        if (i_cmd.abs_en) begin
            r_mag <= r_u[U_W-1] ? (~r_u + 1'b1) : r_u;
        end
        if (i_cmd.dlo_en) begin
            r_dlo <= r_prod[PART_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out <= {1'b0, r_loop_on, r_spin, r_pos, r_rpm, r_duty, r_drive_sign};
        end
    end

    assign o_stat.div_busy = div_busy;
    assign o_stat.loop_on  = r_loop_on;
    assign o_out_data      = r_out;

endmodule

// ===== hdl/ecpi_chk.sv =====
// Port-level checks of the encoder PI speed controller, bound to the top.
// Depends on ecpi_pkg for the result word layout.
module ecpi_chk #(
    parameter int COUNTS_PER_REV = 1024
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [ecpi_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import ecpi_pkg::*;

    // hold a stalled word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result word changed or dropped while stalled");

    // drop the input ready after each accepted word
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input accepted while an event is in flight");

    // a stopped loop drives no duty
    a_stop_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[OUT_RUN_BIT]
            |-> o_m_tdata[OUT_DUTY_LSB +: WORD16_W] == '0)
        else $error("non-zero duty while stopped");

    // keep the shaft position inside one revolution
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[OUT_POS_LSB +: POS_W] < COUNTS_PER_REV)
        else $error("shaft position beyond one revolution");

endmodule

bind encoder_pi_speed_controller ecpi_chk #(
    .COUNTS_PER_REV (COUNTS_PER_REV)
) u_ecpi_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/tb_encoder_pi_speed_controller.sv =====
// Self-checking bench for encoder_pi_speed_controller: random and directed
// events, a bit-exact speed-loop predictor and a checker on every result word.
// Depends on ecpi_pkg and the RTL of encoder_pi_speed_controller only.
module tb_encoder_pi_speed_controller;
    import ecpi_pkg::*;

    localparam int CPR        = 1024;
    localparam int RPM_K      = 6000;
    localparam int SETTLE_CYC = 4;     // quiet cycles before a settings write
    localparam int TAIL_CYC   = 120;   // well above the measure latency
    localparam int MAX_SHOWN  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;  // beyond the list, dropped
    localparam longint DRIVE_MAX = (64'sd1 <<< 39) - 64'sd1;
    localparam longint DRIVE_MIN = -(64'sd1 <<< 39);

    typedef enum logic [1:0] {
        STEP_EVENT,
        STEP_WRITE,
        STEP_WAIT
    } t_step_kind;

    // one entry of the stimulus plan: an event word, a settings write or a pause
    typedef struct {
        t_step_kind              kind;
        t_req                    req;
        logic                    b;
        int                      gap;
        bit                      quiet;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
    } t_plan_step;

    // result word fields, packed so that dir lands on bit 0
    typedef struct packed {
        logic                    run;
        logic                    rot;
        logic [POS_W-1:0]        pos;
        logic [WORD16_W-1:0]     rpm;
        logic [WORD16_W-1:0]     duty;
        logic                    dir;
    } t_motor_status;

    typedef struct {
        t_motor_status st;
        bit            quiet;
    } t_status_due;

    logic                    i_clk = 1'b1;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata = '0;   // [0] b_level, [7:1] zero
    logic [IN_TUSER_W-1:0]   i_s_tuser = '0;   // [1:0] req_type
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    // [0] drive_dir, [16:1] duty, [32:17] speed_rpm, [44:33] shaft_position,
    // [45] rotation_dir, [46] running, [47] zero
    logic [OUT_TDATA_W-1:0]  o_m_tdata;

    encoder_pi_speed_controller #(
        .COUNTS_PER_REV (CPR),
        .RPM_SCALE      (RPM_K)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #2 i_clk = 1'b0;
        #2 i_clk = 1'b1;
    end

    // ------------------------------------------------------------------
    // Speed-loop predictor: settings, encoder counters and PI history
    // ------------------------------------------------------------------
    logic [KP_W-1:0]      gain_p        = KP_RST;
    logic [KP_W-1:0]      gain_i        = KI_TS_RST;
    logic [WORD16_W-1:0]  set_point_rpm = SET_POINT_RST;
    logic [WORD16_W-1:0]  counts_per_v  = DUTY_PV_RST;
    logic [WORD16_W-1:0]  period_cnt    = PWM_PER_RST;

    logic [15:0]          pulses      = '0;
    logic [15:0]          enc_count   = '0;
    logic [15:0]          rpm_now     = '0;
    logic [POS_W-1:0]     angle_now   = '0;
    logic                 turn_ccw    = 1'b0;
    logic [15:0]          target_now  = '0;
    longint               err_last    = 0;
    longint               drive_last  = 0;
    logic                 loop_run    = 1'b0;
    logic [15:0]          duty_now    = '0;
    logic                 drive_neg   = 1'b0;

    task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_KP:        gain_p        = data[KP_W-1:0];
            CFG_KI_TS:     gain_i        = data[KP_W-1:0];
            CFG_SET_POINT: set_point_rpm = data[WORD16_W-1:0];
            CFG_DUTY_PV:   counts_per_v  = data[WORD16_W-1:0];
            CFG_PWM_PER:   period_cnt    = data[WORD16_W-1:0];
            default: ;     // unknown index: the write is dropped
        endcase
    endtask

    // Advance the loop by one event and return the status word it leaves.
    function automatic t_motor_status step_motor(input t_req req, input logic b);
        longint          rpm_wide;
        longint          err;
        longint          drive;
        longint unsigned mag;
        longint unsigned scaled;
        t_motor_status   st;
        case (req)
            REQ_EDGE: begin
                pulses    = pulses + 16'd1;
                turn_ccw  = b;
                enc_count = b ? enc_count - 16'd1 : enc_count + 16'd1;
            end
            REQ_MEASURE: begin
                rpm_wide  = longint'(pulses) * RPM_K / CPR;
                rpm_now   = (rpm_wide > 65535) ? 16'hFFFF : rpm_wide[15:0];
                angle_now = POS_W'(int'(enc_count) % CPR);
                pulses    = '0;
            end
            REQ_CONTROL: begin
                if (loop_run) begin
                    err   = longint'(target_now) - longint'(rpm_now);
                    drive = drive_last + (longint'(gain_p) + longint'(gain_i)) * err
                          - longint'(gain_p) * err_last;
                    if (drive > DRIVE_MAX) drive = DRIVE_MAX;
                    if (drive < DRIVE_MIN) drive = DRIVE_MIN;
                    drive_neg = (drive < 0);
                    mag       = (drive < 0) ? longint'(-drive) : drive;
                    scaled    = (mag * longint'(counts_per_v)) >> 32;
                    if (scaled > longint'(period_cnt)) scaled = period_cnt;
                    duty_now  = scaled[15:0];
                    err_last  = err;
                    drive_last = drive;
                end
            end
            default: begin
                loop_run = !loop_run;
                if (loop_run) target_now = set_point_rpm;
                else          duty_now   = '0;
            end
        endcase
        st.dir  = drive_neg;
        st.duty = duty_now;
        st.rpm  = rpm_now;
        st.pos  = angle_now;
        st.rot  = turn_ccw;
        st.run  = loop_run;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Event driver: feed the plan queue onto the slave side and into the
    // predictor, one word per handshake; settings only when nothing is due
    // ------------------------------------------------------------------
    t_plan_step     plan_q[$];
    t_status_due    status_due_q[$];
    t_plan_step     on_bus;
    int             hold_cnt;
    bit             head_armed;
    int             idle_cnt;
    int             n_taken[4];
    int             n_writes;

    always @(posedge i_clk) begin : drive_events
        logic valid_nx;
        logic we_nx;
        if (!i_rst_n) begin
            i_s_tvalid  <= 1'b0;
            i_cfg_wr_en <= 1'b0;
            hold_cnt    = 0;
            head_armed  = 0;
            idle_cnt    = 0;
        end else begin
            valid_nx = i_s_tvalid;
            we_nx    = 1'b0;
            if (i_s_tvalid && o_s_tready) begin
                status_due_q.push_back('{st: step_motor(on_bus.req, on_bus.b),
                                         quiet: on_bus.quiet});
                n_taken[on_bus.req]++;
                valid_nx = 1'b0;
            end
            // keep a word on the bus until it is taken; otherwise work the plan
            if (!valid_nx && plan_q.size() != 0) begin
                case (plan_q[0].kind)
                    STEP_EVENT: begin
                        if (!head_armed) begin
                            hold_cnt   = plan_q[0].gap;
                            head_armed = 1;
                        end
                        if (hold_cnt > 0) begin
                            hold_cnt--;
                        end else begin
                            on_bus     = plan_q.pop_front();
                            head_armed = 0;
                            valid_nx   = 1'b1;
                            i_s_tuser  <= on_bus.req;
                            i_s_tdata  <= {7'b0, on_bus.b};
                        end
                    end
                    STEP_WRITE: begin
                        // write only once every result has drained and the block has settled
                        if (status_due_q.size() != 0) begin
                            idle_cnt = 0;
                        end else if (idle_cnt < SETTLE_CYC) begin
                            idle_cnt++;
                        end else begin
                            idle_cnt   = 0;
                            we_nx      = 1'b1;
                            i_cfg_idx  <= plan_q[0].idx;
                            i_cfg_data <= plan_q[0].data;
                            apply_setting(plan_q[0].idx, plan_q[0].data);
                            n_writes++;
                            void'(plan_q.pop_front());
                        end
                    end
                    default: begin
                        if (status_due_q.size() == 0) void'(plan_q.pop_front());
                    end
                endcase
            end
            i_s_tvalid  <= valid_nx;
            i_cfg_wr_en <= we_nx;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, compare every word with the
    // oldest prediction, field by field
    // ------------------------------------------------------------------
    int stall_cnt;
    int n_results;
    int n_bad;

    always @(posedge i_clk) begin : check_status
        logic          rdy_nx;
        t_motor_status seen;
        t_status_due   due;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_cnt  = 0;
        end else begin
            rdy_nx = i_m_tready;
            if (o_m_tvalid && i_m_tready) begin
                seen = o_m_tdata[OUT_RUN_BIT:0];
                n_results++;
                if (status_due_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= MAX_SHOWN)
                        $display("result %0d arrived with nothing due: %h",
                                 n_results, o_m_tdata);
                    stall_cnt = $urandom_range(0, 11);
                end else begin
                    due = status_due_q.pop_front();
                    if (seen.dir !== due.st.dir || seen.duty !== due.st.duty ||
                        seen.rpm !== due.st.rpm || seen.pos !== due.st.pos ||
                        seen.rot !== due.st.rot || seen.run !== due.st.run) begin
                        n_bad++;
                        if (n_bad <= MAX_SHOWN) begin
                            $write("result %0d mismatch (expected/actual): ", n_results);
                            $write("dir %0d/%0d duty %0d/%0d rpm %0d/%0d ",
                                   due.st.dir, seen.dir, due.st.duty, seen.duty,
                                   due.st.rpm, seen.rpm);
                            $display("pos %0d/%0d rot %0d/%0d run %0d/%0d",
                                     due.st.pos, seen.pos, due.st.rot, seen.rot,
                                     due.st.run, seen.run);
                        end
                    end
                    stall_cnt = due.quiet ? 0 : $urandom_range(0, 11);
                end
                rdy_nx = 1'b0;
            end
            if (!rdy_nx) begin
                if (stall_cnt > 0) stall_cnt--;
                else               rdy_nx = 1'b1;
            end
            i_m_tready <= rdy_nx;
        end
    end

    // ------------------------------------------------------------------
    // Plan building
    // ------------------------------------------------------------------
    bit plan_quiet;    // no gaps and no back-pressure for the words queued now
    bit plan_running;  // loop state as the plan leaves it

    task automatic add_event(input t_req req, input logic b);
        t_plan_step s;
        s.kind  = STEP_EVENT;
        s.req   = req;
        s.b     = b;
        s.gap   = plan_quiet ? 0 : $urandom_range(0, 11);
        s.quiet = plan_quiet;
        s.idx   = '0;
        s.data  = '0;
        plan_q.push_back(s);
        if (req == REQ_KEY) plan_running = !plan_running;
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        t_plan_step s;
        s.kind  = STEP_WRITE;
        s.req   = REQ_EDGE;
        s.b     = 1'b0;
        s.gap   = 0;
        s.quiet = plan_quiet;
        s.idx   = idx;
        s.data  = data;
        plan_q.push_back(s);
    endtask

    task automatic add_pause();
        t_plan_step s;
        s.kind  = STEP_WAIT;
        s.req   = REQ_EDGE;
        s.b     = 1'b0;
        s.gap   = 0;
        s.quiet = plan_quiet;
        s.idx   = '0;
        s.data  = '0;
        plan_q.push_back(s);
    endtask

    task automatic add_settings(input logic [CFG_DATA_W-1:0] kp_v,
                                input logic [CFG_DATA_W-1:0] ki_v,
                                input logic [CFG_DATA_W-1:0] sp_v,
                                input logic [CFG_DATA_W-1:0] dpv_v,
                                input logic [CFG_DATA_W-1:0] per_v);
        add_write(CFG_KP, kp_v);
        add_write(CFG_KI_TS, ki_v);
        add_write(CFG_SET_POINT, sp_v);
        add_write(CFG_DUTY_PV, dpv_v);
        add_write(CFG_PWM_PER, per_v);
    endtask

    // gains: zero, full scale, the small range around the reset values, or anything
    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom_range(0, 1 << 20));
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    // 16-bit settings carry random upper bits, which the block must drop
    function automatic logic [CFG_DATA_W-1:0] pick_word16();
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom());
        case ($urandom_range(0, 4))
            0:       w[15:0] = '0;
            1:       w[15:0] = '1;
            2, 3:    w[15:0] = 16'($urandom_range(0, 2000));
            default: ;
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : run_plan
        int   n_phase;
        int   n_edges;
        int   n_ctrl;
        bit   paused;
        logic dir;

        plan_quiet   = 0;
        plan_running = 0;

        // reset settings first: control tick while stopped is ignored
        add_event(REQ_CONTROL, 1'b1);
        for (int k = 0; k < 3; k++) add_event(REQ_EDGE, 1'b0);
        // step back past zero: the position count wraps below zero
        for (int k = 0; k < 5; k++) add_event(REQ_EDGE, 1'b1);
        add_event(REQ_MEASURE, 1'b1);
        add_event(REQ_KEY, 1'b0);        // start loads the set-point
        add_event(REQ_CONTROL, 1'b0);
        add_event(REQ_CONTROL, 1'b1);
        add_event(REQ_KEY, 1'b1);        // stop clears duty, direction stays
        add_event(REQ_CONTROL, 1'b0);    // ignored while stopped
        add_event(REQ_KEY, 1'b0);        // restart keeps the PI history
        add_event(REQ_CONTROL, 1'b1);
        add_pause();

        // everything at full scale: drive saturates positive
        add_settings('1, '1, '1, '1, '1);
        add_event(REQ_CONTROL, 1'b0);
        add_event(REQ_KEY, 1'b1);
        add_event(REQ_KEY, 1'b0);
        add_event(REQ_CONTROL, 1'b1);

        // zero target under full gains: drive saturates negative, zero period
        add_settings('1, '1, '0, '1, '0);
        add_event(REQ_KEY, 1'b0);
        add_event(REQ_KEY, 1'b1);
        add_event(REQ_CONTROL, 1'b0);
        add_event(REQ_CONTROL, 1'b1);

        // zero gains and zero scale; spare index must be ignored
        add_settings('0, '0, '0, '0, '1);
        add_write(CFG_SPARE, '1);
        add_event(REQ_CONTROL, 1'b0);

        // back-to-back edges with no gaps and no back-pressure
        plan_quiet = 1;
        add_settings(CFG_DATA_W'(KP_RST), CFG_DATA_W'(KI_TS_RST),
                     CFG_DATA_W'(SET_POINT_RST), CFG_DATA_W'(DUTY_PV_RST),
                     CFG_DATA_W'(PWM_PER_RST));
        for (int k = 0; k < 60; k++) add_event(REQ_EDGE, 1'($urandom_range(0, 1)));
        add_event(REQ_MEASURE, 1'b0);
        add_event(REQ_CONTROL, 1'b0);

        // random phases: mostly edge bursts followed by a measure and control ticks
        for (int ph = 0; ph < 6; ph++) begin
            plan_quiet = (ph % 4 == 3);
            add_settings(pick_gain(), pick_gain(), pick_word16(), pick_word16(),
                         pick_word16());
            if ($urandom_range(0, 3) == 0) add_write(CFG_SPARE, CFG_DATA_W'($urandom()));
            if (!plan_running) add_event(REQ_KEY, 1'($urandom_range(0, 1)));
            n_phase = 0;
            paused  = 0;
            while (n_phase < 80) begin
                case ($urandom_range(0, 9))
                    0: begin
                        add_event(REQ_KEY, 1'($urandom_range(0, 1)));
                        n_phase++;
                    end
                    1: begin
                        add_event(t_req'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                        n_phase++;
                    end
                    default: begin
                        n_edges = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 80)
                                                               : $urandom_range(0, 12);
                        n_ctrl  = $urandom_range(1, 3);
                        dir     = 1'($urandom_range(0, 1));
                        for (int k = 0; k < n_edges; k++)
                            add_event(REQ_EDGE, ($urandom_range(0, 7) == 0) ? !dir : dir);
                        add_event(REQ_MEASURE, 1'($urandom_range(0, 1)));
                        for (int k = 0; k < n_ctrl; k++)
                            add_event(REQ_CONTROL, 1'($urandom_range(0, 1)));
                        n_phase += n_edges + n_ctrl + 1;
                    end
                endcase
                // let the output side drain completely once per phase
                if (!paused && n_phase >= 40) begin
                    add_pause();
                    paused = 1;
                end
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (plan_q.size() != 0 || i_s_tvalid || status_due_q.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("Covered %0d encoder edges, %0d measure ticks, %0d control ticks, %0d keys",
                 n_taken[REQ_EDGE], n_taken[REQ_MEASURE], n_taken[REQ_CONTROL],
                 n_taken[REQ_KEY]);
        $display("%0d settings writes, %0d result words checked, %0d bad",
                 n_writes, n_results, n_bad);
        if (n_bad == 0 && status_due_q.size() == 0) begin
            $display("PASS encoder_pi_speed_controller");
        end else begin
            $display("FAIL encoder_pi_speed_controller");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin : watchdog
        #1000000;
        $display("FAIL encoder_pi_speed_controller");
        $finish;
    end

endmodule
